// ===== src/tia_pkg.sv =====
// Package for the typed id allocator: widths, codes, controller states and the
// command and status structs passed between the controller and the datapath.
// Depends on nothing.
package tia_pkg;

  localparam int NUM_TYPES_DEF      = 8;
  localparam int SLOTS_PER_TYPE_DEF = 256;

  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int TYPE_F_W = 3;
  localparam int SUB_W    = 5;
  localparam int SLOT_W   = 8;
  localparam int ID_W     = 16;
  localparam int LIMIT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 24;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd;
    logic advance;
    logic commit;
    logic reject;
    logic push;
  } ctl_cmd_t;

  typedef struct packed {
    logic req_bad;
    logic found;
    logic last_word;
    logic op_free;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/tia_ctrl.sv =====
// Controller state machine of the typed id allocator.
// Sequences capture, word reads, the scan and the result hand-off.
// Depends on tia_pkg.
module tia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  tia_pkg::dp_status_t status,
  output tia_pkg::ctl_cmd_t   cmd
);
  import tia_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_READ;
      end
      S_READ: begin
        state_next = status.req_bad ? S_PUSH : S_SCAN;
      end
      S_SCAN: begin
        if (status.op_free || status.found || status.last_word) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      S_READ: begin
        cmd.reject = status.req_bad;
        cmd.rd     = !status.req_bad;
      end
      S_SCAN: begin
        if (status.op_free || status.found) begin
          cmd.commit = 1'b1;
        end else if (status.last_word) begin
          cmd.reject = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_PUSH: begin
        cmd.push = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/tia_dp.sv =====
// Datapath of the typed id allocator: request registers, the used-flag memory
// of 32-bit words with per-row valid bits, the first-free search and the output register.
// Depends on tia_pkg.
module tia_dp #(
  parameter int NUM_TYPES      = tia_pkg::NUM_TYPES_DEF,
  parameter int SLOTS_PER_TYPE = tia_pkg::SLOTS_PER_TYPE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tia_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic                          in_cmd,
  input  logic [tia_pkg::TYPE_F_W-1:0]  in_type,
  input  logic [tia_pkg::SUB_W-1:0]     in_subtype,
  input  logic [tia_pkg::ID_W-1:0]      in_free_id,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tia_pkg::ID_W-1:0]      m_tdata,
  output logic [tia_pkg::STATUS_W-1:0]  m_tuser,
  input  tia_pkg::ctl_cmd_t             cmd,
  output tia_pkg::dp_status_t           status
);
  import tia_pkg::*;

  localparam int WORDS  = (SLOTS_PER_TYPE + WORD_W - 1) / WORD_W;
  localparam int WSEL_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int ADDR_W = TYPE_W + WSEL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [LIMIT_W-1:0]  slot_limit;
  logic [LIMIT_W-1:0]  lim;
  logic                op;
  logic [TYPE_F_W-1:0] typ;
  logic [SUB_W-1:0]    sub;
  logic [SLOT_W-1:0]   slot;
  logic                fid_zero;
  logic [WSEL_W-1:0]   word;
  logic [WSEL_W-1:0]   rd_word;
  logic [ID_W-1:0]     res_id;
  logic [STATUS_W-1:0] res_status;

  logic [WORD_W-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]    row_valid;
  logic [WORD_W-1:0]   rdata;
  logic                rdata_valid;
  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   waddr;
  logic                re;
  logic [WORD_W-1:0]   wdata;

  logic [WORD_W-1:0]   cur;
  logic [LIMIT_W-1:0]  base;
  logic [LIMIT_W-1:0]  rem;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   free_bits;
  logic [BIT_W-1:0]    pos;
  logic [LIMIT_W-1:0]  found_slot;
  logic                type_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      slot_limit <= cfg_wdata;
    end
  end

  assign lim = (slot_limit < LIMIT_W'(SLOTS_PER_TYPE)) ? slot_limit : LIMIT_W'(SLOTS_PER_TYPE);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= in_cmd;
      sub      <= in_subtype;
      slot     <= in_free_id[SLOT_W-1:0];
      fid_zero <= (in_free_id == '0);
      if (in_cmd == CMD_FREE) begin
        typ  <= in_free_id[ID_W-1 -: TYPE_F_W];
        word <= in_free_id[BIT_W +: WSEL_W];
      end else begin
        typ  <= in_type;
        word <= '0;
      end
    end else if (cmd.advance) begin
      word <= word + 1'b1;
    end
  end

  assign type_bad = ({29'd0, typ} >= NUM_TYPES);

  assign status.req_bad = (op == CMD_FREE) ? (fid_zero || type_bad || ({1'b0, slot} >= lim))
                                           : (type_bad || (lim == '0));

  assign rd_word = cmd.advance ? word + 1'b1 : word;
  assign raddr   = {typ[TYPE_W-1:0], rd_word};
  assign waddr   = {typ[TYPE_W-1:0], word};
  assign re      = cmd.rd || cmd.advance;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata       <= mem[raddr];
      rdata_valid <= row_valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.commit) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  assign cur  = rdata_valid ? rdata : '0;
  assign base = LIMIT_W'({word, BIT_W'(0)});
  assign rem  = lim - base;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      mask[b] = (LIMIT_W'(b) < rem);
    end
  end

  assign free_bits = ~cur & mask;

  always_comb begin
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) pos = BIT_W'(b);
    end
  end

  assign found_slot = base + LIMIT_W'(pos);

  always_comb begin
    if (op == CMD_FREE) begin
      wdata = cur & ~(WORD_W'(1) << slot[BIT_W-1:0]);
    end else begin
      wdata = cur | (WORD_W'(1) << pos);
    end
  end

  assign status.found     = |free_bits;
  assign status.last_word = ({1'b0, base} + (LIMIT_W + 1)'(WORD_W)) >= {1'b0, lim};
  assign status.op_free   = (op == CMD_FREE);
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      res_id     <= '0;
      res_status <= (op == CMD_FREE) ? STATUS_IGNORED : STATUS_FULL;
    end else if (cmd.commit) begin
      res_status <= STATUS_DONE;
      if (op == CMD_FREE) begin
        res_id <= '0;
      end else begin
        res_id <= {typ, sub, found_slot[SLOT_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= res_id;
      m_tuser <= res_status;
    end
  end

endmodule

// ===== src/typed_id_allocator_unit.sv =====
// Top level of the typed id allocator: joins the controller and the datapath.
// Depends on tia_pkg, tia_ctrl and tia_dp.
//
// Each input transaction is one command. s_tuser selects allocate or free.
// An allocation searches the used flags of one type, a 32-bit word per
// cycle, for the lowest free slot below the slot limit and returns the
// packed id on m_tdata with a status on m_tuser. A free clears one flag.
// Every command gives exactly one output transaction.
// An allocation reads one to eight flag words, a valid free reads one
// and a request that fails the check reads none; one command is in
// work at a time, through the one read port of the flag memory.
// The slot limit is written through cfg_we and cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce.
// Reset frees every slot at once through per-row valid bits and sets the
// limit to 256. A result waits in the output register while m_tready is
// low; the next command is accepted, and held before its hand-off if the
// earlier result has still not been taken.
module typed_id_allocator_unit #(
  parameter int NUM_TYPES      = tia_pkg::NUM_TYPES_DEF,
  parameter int SLOTS_PER_TYPE = tia_pkg::SLOTS_PER_TYPE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tia_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [2:0] id_type, [7:3] id_subtype, [23:8] free_id
  input  logic [tia_pkg::IN_W-1:0]     s_tdata,
  // [0] cmd
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [15:0] new_id
  output logic [tia_pkg::ID_W-1:0]     m_tdata,
  // [1:0] status
  output logic [tia_pkg::STATUS_W-1:0] m_tuser
);
  import tia_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  tia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tia_dp #(
    .NUM_TYPES      (NUM_TYPES),
    .SLOTS_PER_TYPE (SLOTS_PER_TYPE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (s_tuser),
    .in_type    (s_tdata[2:0]),
    .in_subtype (s_tdata[7:3]),
    .in_free_id (s_tdata[23:8]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
